@@ hdl/ppi_pkg.sv @@
`default_nettype none

package ppi_pkg;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        PORT_A    = 2'd0,
        PORT_B    = 2'd1,
        PORT_C    = 2'd2,
        PORT_CTRL = 2'd3
    } port_t;

    localparam logic [7:0] CTRL_RESET  = 8'h9B;
    localparam logic [7:0] ALL_ONES    = 8'hFF;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

    // control byte bit positions
    localparam int CTRL_MODE_SET_BIT = 7;
    localparam int CTRL_A_IN_BIT     = 4;
    localparam int CTRL_CHI_IN_BIT   = 3;
    localparam int CTRL_B_IN_BIT     = 1;
    localparam int CTRL_CLO_IN_BIT   = 0;

    // port C bit fed by the pad data line
    localparam int PAD_BIT = 4;

    typedef struct packed {
        action_t    action;
        port_t      port_sel;
        logic [7:0] write_data;
        logic       pad_level;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pad_drive;
        logic       pad_latch;
        logic       pad_clock;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/ppi_req_if.sv @@
`default_nettype none

interface ppi_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [1:0] port_sel;
    logic [7:0] write_data;
    logic       pad_level;

    modport source (output valid, action, port_sel, write_data, pad_level, input ready);
    modport sink   (input valid, action, port_sel, write_data, pad_level, output ready);
endinterface

`default_nettype wire

@@ hdl/ppi_res_if.sv @@
`default_nettype none

interface ppi_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       pad_drive;
    logic       pad_latch;
    logic       pad_clock;

    modport source (output valid, read_data, pad_drive, pad_latch, pad_clock, input ready);
    modport sink   (input valid, read_data, pad_drive, pad_latch, pad_clock, output ready);
endinterface

`default_nettype wire

@@ hdl/ppi_core.sv @@
`default_nettype none

module ppi_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire ppi_pkg::req_t req,
    output ppi_pkg::res_t      res
);

    logic [7:0] control_byte_reg, control_byte_next;
    logic [7:0] latch_a_reg, latch_a_next;
    logic [7:0] latch_b_reg, latch_b_next;
    logic [7:0] latch_c_reg, latch_c_next;
    logic [7:0] c_sampled;
    logic [7:0] read_data;
    logic       pad_drive;
    logic       a_in, b_in, chi_in, clo_in;

    assign a_in   = control_byte_reg[ppi_pkg::CTRL_A_IN_BIT];
    assign b_in   = control_byte_reg[ppi_pkg::CTRL_B_IN_BIT];
    assign chi_in = control_byte_reg[ppi_pkg::CTRL_CHI_IN_BIT];
    assign clo_in = control_byte_reg[ppi_pkg::CTRL_CLO_IN_BIT];

    always_comb
    begin
        c_sampled = latch_c_reg;
        c_sampled[ppi_pkg::PAD_BIT] = req.pad_level;

        control_byte_next = control_byte_reg;
        latch_a_next      = latch_a_reg;
        latch_b_next      = latch_b_reg;
        latch_c_next      = latch_c_reg;
        read_data         = ppi_pkg::ALL_ONES;
        pad_drive         = 1'b0;

        if (req.action == ppi_pkg::ACT_READ)
        begin
            unique case (req.port_sel)
                ppi_pkg::PORT_A:
                begin
                    if (!a_in)
                        read_data = latch_a_reg;
                end
                ppi_pkg::PORT_B:
                begin
                    if (!b_in)
                        read_data = latch_b_reg;
                end
                ppi_pkg::PORT_C:
                begin
                    latch_c_next = c_sampled;
                    if (!chi_in)
                        read_data = (read_data & ppi_pkg::LOW_NIBBLE)
                                  | (c_sampled & ppi_pkg::HIGH_NIBBLE);
                    if (!clo_in)
                        read_data = (read_data & ppi_pkg::HIGH_NIBBLE)
                                  | (c_sampled & ppi_pkg::LOW_NIBBLE);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (req.port_sel)
                ppi_pkg::PORT_A:
                begin
                    if (!a_in)
                        latch_a_next = req.write_data;
                end
                ppi_pkg::PORT_B:
                begin
                    if (!b_in)
                        latch_b_next = req.write_data;
                end
                ppi_pkg::PORT_C:
                begin
                    latch_c_next = req.write_data;
                end
                default:
                begin
                    if (req.write_data[ppi_pkg::CTRL_MODE_SET_BIT])
                    begin
                        control_byte_next = req.write_data;
                        latch_a_next      = '0;
                        latch_b_next      = '0;
                        latch_c_next      = '0;
                    end
                    else
                    begin
                        // bit set/reset: bits 3..1 pick the bit, bit 0 is its value
                        latch_c_next[req.write_data[3:1]] = req.write_data[0];
                        pad_drive = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_byte_reg <= ppi_pkg::CTRL_RESET;
            latch_a_reg      <= '0;
            latch_b_reg      <= '0;
            latch_c_reg      <= '0;
        end
        else if (step)
        begin
            control_byte_reg <= control_byte_next;
            latch_a_reg      <= latch_a_next;
            latch_b_reg      <= latch_b_next;
            latch_c_reg      <= latch_c_next;
        end
    end

    assign res.read_data = read_data;
    assign res.pad_drive = pad_drive;
    assign res.pad_latch = latch_c_next[0];
    assign res.pad_clock = latch_c_next[1];

    a_mode_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && req.action == ppi_pkg::ACT_WRITE && req.port_sel == ppi_pkg::PORT_CTRL
         && req.write_data[ppi_pkg::CTRL_MODE_SET_BIT])
        |=> (latch_a_reg == '0 && latch_b_reg == '0 && latch_c_reg == '0))
        else $error("mode set did not clear latches");

    a_drive_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        pad_drive |-> (read_data == ppi_pkg::ALL_ONES))
        else $error("pad drive on a read");

    a_ctrl_held: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(control_byte_reg))
        else $error("control byte changed without a request");

endmodule

`default_nettype wire

@@ hdl/parallel_port_interface_regs.sv @@
// Mode 0 parallel port register block. Takes one bus request per cycle while
// the result side is not stalled: the request lands in an input register, passes
// through the port access logic, which updates the control byte and the A/B/C
// latches, and its result is held in a result register until taken. Requests
// are handled strictly in order; a stalled result stops the input stage only
// once that stage is also full.
`default_nettype none

module parallel_port_interface_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ppi_req_if.sink     req,
    ppi_res_if.source   res
);

    logic          in_valid_reg;
    ppi_pkg::req_t in_req_reg;
    logic          out_valid_reg;
    ppi_pkg::res_t out_res_reg;
    ppi_pkg::res_t core_res;
    logic          advance;
    logic          in_fire;

    assign advance = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_fire = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_req_reg.action     <= ppi_pkg::action_t'(req.action);
            in_req_reg.port_sel   <= ppi_pkg::port_t'(req.port_sel);
            in_req_reg.write_data <= req.write_data;
            in_req_reg.pad_level  <= req.pad_level;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    ppi_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (in_req_reg),
        .res   (core_res)
    );

    assign res.valid     = out_valid_reg;
    assign res.read_data = out_res_reg.read_data;
    assign res.pad_drive = out_res_reg.pad_drive;
    assign res.pad_latch = out_res_reg.pad_latch;
    assign res.pad_clock = out_res_reg.pad_clock;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !res.ready) |-> !req.ready)
        else $error("request taken while both stages are full");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request has no result");

    a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_valid_reg)
        else $error("accepted request lost from input stage");

endmodule

`default_nettype wire

@@ dv/ppi_access_check.sv @@
`default_nettype none

module ppi_access_check
    import ppi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ppi_req_if        req,
    ppi_res_if        res,
    input  wire logic drain_done,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the port registers
    logic [7:0] ctrl_q  = CTRL_RESET;
    logic [7:0] latch_a = '0;
    logic [7:0] latch_b = '0;
    logic [7:0] latch_c = '0;

    res_t expected_results[$];
    int   errors        = 0;
    int   waiting       = 0;
    bit   drain_checked = 1'b0;

    assign fail_count = errors;
    assign pending    = waiting;

    task automatic report(input string msg);
        begin
            $display("%0t ERROR %s", $realtime, msg);
            errors++;
        end
    endtask

    function automatic res_t predict_access(input req_t r);
        res_t rsp;
        logic [7:0] wd;
        begin
            wd            = r.write_data;
            rsp.read_data = ALL_ONES;
            rsp.pad_drive = 1'b0;
            if (r.action == ACT_WRITE)
            begin
                case (r.port_sel)
                    PORT_A: if (!ctrl_q[CTRL_A_IN_BIT]) latch_a = wd;
                    PORT_B: if (!ctrl_q[CTRL_B_IN_BIT]) latch_b = wd;
                    PORT_C: latch_c = wd;
                    default:
                    begin
                        if (wd[CTRL_MODE_SET_BIT])
                        begin
                            ctrl_q  = wd;
                            latch_a = '0;
                            latch_b = '0;
                            latch_c = '0;
                        end
                        else
                        begin
                            // bit set/reset: bits 3..1 pick the bit, bit 0 is the value
                            latch_c[wd[3:1]] = wd[0];
                            rsp.pad_drive    = 1'b1;
                        end
                    end
                endcase
            end
            else
            begin
                case (r.port_sel)
                    PORT_A: if (!ctrl_q[CTRL_A_IN_BIT]) rsp.read_data = latch_a;
                    PORT_B: if (!ctrl_q[CTRL_B_IN_BIT]) rsp.read_data = latch_b;
                    PORT_C:
                    begin
                        latch_c[PAD_BIT] = r.pad_level;
                        if (!ctrl_q[CTRL_CHI_IN_BIT])
                            rsp.read_data = (rsp.read_data & LOW_NIBBLE) | (latch_c & HIGH_NIBBLE);
                        if (!ctrl_q[CTRL_CLO_IN_BIT])
                            rsp.read_data = (rsp.read_data & HIGH_NIBBLE) | (latch_c & LOW_NIBBLE);
                    end
                    default: ;
                endcase
            end
            rsp.pad_latch = latch_c[0];
            rsp.pad_clock = latch_c[1];
            return rsp;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        req_t r;
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            ctrl_q  = CTRL_RESET;
            latch_a = '0;
            latch_b = '0;
            latch_c = '0;
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            // result side first: a request never completes in its own cycle
            if (res.valid && res.ready)
            begin
                got.read_data = res.read_data;
                got.pad_drive = res.pad_drive;
                got.pad_latch = res.pad_latch;
                got.pad_clock = res.pad_clock;
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result data=%02h", got.read_data));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report($sformatf("read_data %02h, want %02h", got.read_data,
                                         want.read_data));
                    if (got.pad_drive !== want.pad_drive)
                        report($sformatf("pad_drive %b, want %b", got.pad_drive,
                                         want.pad_drive));
                    if (got.pad_latch !== want.pad_latch)
                        report($sformatf("pad_latch %b, want %b", got.pad_latch,
                                         want.pad_latch));
                    if (got.pad_clock !== want.pad_clock)
                        report($sformatf("pad_clock %b, want %b", got.pad_clock,
                                         want.pad_clock));
                end
            end
            if (req.valid && req.ready)
            begin
                r.action     = action_t'(req.action);
                r.port_sel   = port_t'(req.port_sel);
                r.write_data = req.write_data;
                r.pad_level  = req.pad_level;
                expected_results.push_back(predict_access(r));
            end
            if (drain_done && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (expected_results.size() != 0)
                    report($sformatf("%0d results never arrived", expected_results.size()));
            end
            waiting = expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_parallel_port_interface_regs.sv @@
`default_nettype none

module tb_parallel_port_interface_regs;
    import ppi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1300;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 200;

    logic clk = 1'b0;
    logic rst_n;
    logic drain_done = 1'b0;
    int   fail_count;
    int   pending;
    int   sent_count  = 0;
    int   cycle_count = 0;

    ppi_req_if req_ch ();
    ppi_res_if res_ch ();

    parallel_port_interface_regs dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    ppi_access_check u_access_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .drain_done (drain_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit in_quiet_window();
        return sent_count >= QUIET_FROM && sent_count < QUIET_TO;
    endfunction

    function automatic req_t mk(input action_t act, input port_t port,
                                input logic [7:0] wd, input logic pad);
        req_t r;
        begin
            r.action     = act;
            r.port_sel   = port;
            r.write_data = wd;
            r.pad_level  = pad;
            return r;
        end
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        begin
            pick         = $urandom_range(99);
            r.action     = action_t'($urandom_range(1));
            r.port_sel   = port_t'($urandom_range(2));
            r.write_data = 8'($urandom_range(255));
            r.pad_level  = 1'($urandom_range(1));
            if (pick < 4)
            begin
                // mode set: clears all latches, so keep it rare
                r.action     = ACT_WRITE;
                r.port_sel   = PORT_CTRL;
                r.write_data[CTRL_MODE_SET_BIT] = 1'b1;
            end
            else if (pick < 18)
            begin
                r.action     = ACT_WRITE;
                r.port_sel   = PORT_CTRL;
                r.write_data[CTRL_MODE_SET_BIT] = 1'b0;
            end
            else if (pick < 21)
            begin
                r.action   = ACT_READ;
                r.port_sel = PORT_CTRL;
            end
            return r;
        end
    endfunction

    task automatic send_request(input req_t r);
        begin
            while (!in_quiet_window() && $urandom_range(99) < 32)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
            req_ch.valid      <= 1'b1;
            req_ch.action     <= r.action;
            req_ch.port_sel   <= r.port_sel;
            req_ch.write_data <= r.write_data;
            req_ch.pad_level  <= r.pad_level;
            @(posedge clk);
            while (!req_ch.ready) @(posedge clk);
            sent_count++;
            @(negedge clk);
        end
    endtask

    // result side: random stalls, one long hold-off to back up the pipe
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent_count >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (in_quiet_window())
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= 32);
        end
    end

    initial
    begin
        req_t directed_reqs[$];
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_READ;
        req_ch.port_sel   = PORT_A;
        req_ch.write_data = '0;
        req_ch.pad_level  = 1'b0;

        // all ports start as inputs
        directed_reqs.push_back(mk(ACT_READ,  PORT_A,    8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_B,    8'hFF, 1'b1));
        directed_reqs.push_back(mk(ACT_READ,  PORT_C,    8'h00, 1'b1));
        directed_reqs.push_back(mk(ACT_READ,  PORT_CTRL, 8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_A,    8'h3C, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_C,    8'hA5, 1'b0));
        // all outputs, latches cleared
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h80, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_A,    8'hFF, 1'b1));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_B,    8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_C,    8'h5A, 1'b1));
        directed_reqs.push_back(mk(ACT_READ,  PORT_A,    8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_B,    8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_C,    8'h00, 1'b1));
        directed_reqs.push_back(mk(ACT_READ,  PORT_C,    8'hFF, 1'b0));
        // bit set/reset, including ignored bits 6..4
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h01, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h03, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h7F, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h0E, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h00, 1'b0));
        // split port C directions
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h81, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_C,    8'hF0, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_C,    8'h00, 1'b0));
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'h8A, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_C,    8'h00, 1'b1));
        // mode 2 bits, all inputs
        directed_reqs.push_back(mk(ACT_WRITE, PORT_CTRL, 8'hFF, 1'b0));
        directed_reqs.push_back(mk(ACT_READ,  PORT_B,    8'h00, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_reqs[i])
            send_request(directed_reqs[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_request(random_request());
        req_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        drain_done <= 1'b1;
        @(negedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
